// ===== hw/rtl/lcdt_pkg.sv =====
// shared constants, state encoding and init table for the lcd terminal
package lcdt_pkg;

  // display commands
  localparam logic [7:0] CMD_FUNCSET = 8'h28;
  localparam logic [7:0] CMD_DISPOFF = 8'h08;
  localparam logic [7:0] CMD_CLEAR   = 8'h01;
  localparam logic [7:0] CMD_ENTRY   = 8'h06;
  localparam logic [7:0] CMD_DISPON  = 8'h0C;
  localparam logic [7:0] CMD_HOME    = 8'h02;
  localparam logic [7:0] CMD_LINE2   = 8'hC0;

  // init nibbles
  localparam logic [3:0] NIB_WAKE = 4'h3;
  localparam logic [3:0] NIB_4BIT = 4'h2;

  localparam logic [7:0] BLANK      = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_RETURN  = 8'd13;

  localparam logic OP_PUT   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // index of the final init transfer
  localparam logic [3:0] INIT_LAST = 4'd8;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_INIT   = 5'b00010,
    S_EXEC   = 5'b00100,
    S_SCROLL = 5'b01000,
    S_TAIL   = 5'b10000
  } state_e;

  typedef struct packed {
    logic [7:0] value;
    logic       nibble_only;
  } init_xfer_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic clr_all;
  } store_ctl_t;

  function automatic init_xfer_t init_xfer(input logic [3:0] step);
    init_xfer_t x;
    x.nibble_only = 1'b0;
    x.value       = CMD_DISPON;
    case (step)
      4'd0, 4'd1, 4'd2: begin
        x.value       = {4'h0, NIB_WAKE};
        x.nibble_only = 1'b1;
      end
      4'd3: begin
        x.value       = {4'h0, NIB_4BIT};
        x.nibble_only = 1'b1;
      end
      4'd4: x.value = CMD_FUNCSET;
      4'd5: x.value = CMD_DISPOFF;
      4'd6: x.value = CMD_CLEAR;
      4'd7: x.value = CMD_ENTRY;
      default: x.value = CMD_DISPON;
    endcase
    return x;
  endfunction

endpackage

// ===== hw/rtl/lcdt_if.sv =====
// valid/ready channel interfaces for characters in and bus transfers out
interface lcdt_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] char_code;

  modport source (output valid, output op, output char_code, input ready);
  modport sink (input valid, input op, input char_code, output ready);
endinterface

interface lcdt_out_if;
  logic       valid;
  logic       ready;
  logic       is_data;
  logic [7:0] value;
  logic       nibble_only;
  logic       last;

  modport source (output valid, output is_data, output value, output nibble_only,
                  output last, input ready);
  modport sink (input valid, input is_data, input value, input nibble_only,
                input last, output ready);
endinterface

// ===== hw/rtl/char_lcd_scrolling_terminal_unit.sv =====
// two-line character lcd terminal: characters in, display bus transfers out
// Each accepted character or clear request is turned into display bus transfers, one per
// cycle while the sink takes them, ending with a transfer flagged last; a character past
// the end of the line produces none. The input is ready only between items. An ordinary
// item passes from acceptance through the execute state into the output register; the
// first item after reset adds the 9-transfer init sequence, and a newline on line 2
// scrolls with LINE_WIDTH + 2 transfers. The rate is set by the transfer sequencer, which
// loads one transfer per cycle into the output register, and by the single read port of
// the line store, whose registered read is issued together with the preceding transfer.
module char_lcd_scrolling_terminal_unit #(
  parameter int unsigned LINE_WIDTH = 16
) (
  input logic       clk_i,
  input logic       rst_ni,
  lcdt_in_if.sink   in_i,
  lcdt_out_if.source out_o
);
  import lcdt_pkg::*;

  localparam int unsigned IDX_W  = $clog2(LINE_WIDTH);
  localparam int unsigned COL_W  = $clog2(LINE_WIDTH + 1);
  localparam int unsigned STEP_W = (IDX_W > 4) ? IDX_W : 4;

  localparam logic [COL_W-1:0]  COL_FULL    = COL_W'(LINE_WIDTH);
  localparam logic [STEP_W-1:0] SCROLL_LAST = STEP_W'(LINE_WIDTH - 1);
  localparam logic [STEP_W-1:0] INIT_END    = STEP_W'(INIT_LAST);

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d, step_nxt;
  logic              init_q, init_d;
  logic              line2_q, line2_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic              op_q;
  logic [7:0]        ch_q;

  logic              out_valid_q, out_valid_d;
  logic              out_is_data_q;
  logic [7:0]        out_value_q;
  logic              out_nib_q;
  logic              out_last_q;

  logic              in_acc, adv;
  logic              emit, e_is_data, e_nib, e_last;
  logic [7:0]        e_value;
  init_xfer_t        ix;
  store_ctl_t        st_ctl;
  logic [IDX_W-1:0]  rd_addr;
  logic [7:0]        rd_data;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  // output register free or being emptied this cycle
  assign adv        = !out_valid_q || out_o.ready;
  assign step_nxt   = step_q + STEP_W'(1);
  assign ix         = init_xfer(step_q[3:0]);

  lcdt_line_store #(
    .LINE_WIDTH(LINE_WIDTH)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (st_ctl),
    .wr_addr_i(col_q[IDX_W-1:0]),
    .wr_data_i(ch_q),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    init_d    = init_q;
    line2_d   = line2_q;
    col_d     = col_q;
    emit      = 1'b0;
    e_is_data = 1'b0;
    e_value   = CMD_CLEAR;
    e_nib     = 1'b0;
    e_last    = 1'b0;
    st_ctl    = '0;
    rd_addr   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          state_d = init_q ? S_EXEC : S_INIT;
          step_d  = '0;
        end
      end
      S_INIT: begin
        if (adv) begin
          emit    = 1'b1;
          e_value = ix.value;
          e_nib   = ix.nibble_only;
          step_d  = step_nxt;
          if (step_q == INIT_END) begin
            init_d         = 1'b1;
            col_d          = '0;
            st_ctl.clr_all = 1'b1;
            state_d        = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (adv) begin
          state_d = S_IDLE;
          if (op_q == OP_CLEAR) begin
            emit    = 1'b1;
            e_value = CMD_CLEAR;
            e_last  = 1'b1;
            line2_d = 1'b0;
            col_d   = '0;
          end else if (ch_q == CH_NEWLINE) begin
            if (line2_q) begin
              // scroll: clear now, prefetch entry 0 for the rewrite
              emit         = 1'b1;
              e_value      = CMD_CLEAR;
              st_ctl.rd_en = 1'b1;
              step_d       = '0;
              state_d      = S_SCROLL;
            end else begin
              emit    = 1'b1;
              e_value = CMD_LINE2;
              e_last  = 1'b1;
              line2_d = 1'b1;
              col_d   = '0;
            end
          end else if (ch_q == CH_RETURN) begin
            emit    = 1'b1;
            e_value = line2_q ? CMD_LINE2 : CMD_HOME;
            e_last  = 1'b1;
            col_d   = '0;
          end else if (col_q < COL_FULL) begin
            emit         = 1'b1;
            e_is_data    = 1'b1;
            e_value      = ch_q;
            e_last       = 1'b1;
            st_ctl.wr_en = 1'b1;
            col_d        = col_q + COL_W'(1);
          end
        end
      end
      S_SCROLL: begin
        if (adv) begin
          emit      = 1'b1;
          e_is_data = 1'b1;
          e_value   = rd_data;
          step_d    = step_nxt;
          if (step_q == SCROLL_LAST) begin
            st_ctl.clr_all = 1'b1;
            state_d        = S_TAIL;
          end else begin
            st_ctl.rd_en = 1'b1;
            rd_addr      = step_nxt[IDX_W-1:0];
          end
        end
      end
      S_TAIL: begin
        if (adv) begin
          emit    = 1'b1;
          e_value = CMD_LINE2;
          e_last  = 1'b1;
          line2_d = 1'b1;
          col_d   = '0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      init_q      <= 1'b0;
      line2_q     <= 1'b0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      init_q      <= init_d;
      line2_q     <= line2_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q <= in_i.op;
      ch_q <= in_i.char_code;
    end
    if (emit) begin
      out_is_data_q <= e_is_data;
      out_value_q   <= e_value;
      out_nib_q     <= e_nib;
      out_last_q    <= e_last;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.is_data     = out_is_data_q;
  assign out_o.value       = out_value_q;
  assign out_o.nibble_only = out_nib_q;
  assign out_o.last        = out_last_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_first_item_inits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !init_q |=> state_q == S_INIT)
    else $error("first transaction did not start the init sequence");

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && e_last |=> state_q == S_IDLE)
    else $error("item continued after its last transfer");

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= COL_FULL)
    else $error("column ran past the line width");

endmodule

// ===== hw/rtl/lcdt_line_store.sv =====
// line store memory with per-entry valid bits, unwritten entries read as blank
module lcdt_line_store #(
  parameter int unsigned LINE_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lcdt_pkg::store_ctl_t          ctl_i,
  input  logic [$clog2(LINE_WIDTH)-1:0] wr_addr_i,
  input  logic [7:0]                    wr_data_i,
  input  logic [$clog2(LINE_WIDTH)-1:0] rd_addr_i,
  output logic [7:0]                    rd_data_o
);
  import lcdt_pkg::*;

  logic [7:0]            mem_q [LINE_WIDTH];
  logic [LINE_WIDTH-1:0] vld_q;
  logic [7:0]            rd_q;
  logic                  rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctl_i.clr_all) begin
        vld_q <= '0;
      end else if (ctl_i.wr_en) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : BLANK;

endmodule

// ===== test/char_lcd_scrolling_terminal_unit_tb.sv =====
// testbench for the lcd terminal: directed table and random text, checked against a line model
module char_lcd_scrolling_terminal_unit_tb;
  import lcdt_pkg::*;

  localparam int LINE_WIDTH   = 16;
  localparam int ITEM_TARGET  = 330;
  localparam int LIMIT_CYCLES = 600000;

  typedef struct packed {
    logic       is_data;
    logic [7:0] value;
    logic       nibble_only;
    logic       last;
  } lcd_xfer_t;

  // one directed row, repeated reps times; typed rows pin the final transfer
  typedef struct packed {
    logic       op;
    logic [7:0] ch;
    logic [4:0] reps;
    logic       typed;
    logic       t_is_data;
    logic [7:0] t_value;
  } script_row_t;

  localparam script_row_t OPENING [11] = '{
    '{OP_CLEAR, 8'hFF,      5'd1,  1'b1, 1'b0, CMD_CLEAR},  // first use: init then clear
    '{OP_PUT,   8'h00,      5'd1,  1'b1, 1'b1, 8'h00},
    '{OP_PUT,   8'hFF,      5'd1,  1'b1, 1'b1, 8'hFF},
    '{OP_PUT,   CH_RETURN,  5'd1,  1'b1, 1'b0, CMD_HOME},
    '{OP_PUT,   CH_NEWLINE, 5'd1,  1'b1, 1'b0, CMD_LINE2},
    '{OP_PUT,   CH_RETURN,  5'd1,  1'b1, 1'b0, CMD_LINE2},
    '{OP_PUT,   8'h41,      5'd17, 1'b0, 1'b0, 8'h00},      // last one falls off the line
    '{OP_PUT,   CH_NEWLINE, 5'd1,  1'b1, 1'b0, CMD_LINE2},  // scroll
    '{OP_CLEAR, 8'h00,      5'd1,  1'b1, 1'b0, CMD_CLEAR},
    '{OP_PUT,   CH_NEWLINE, 5'd1,  1'b1, 1'b0, CMD_LINE2},
    '{OP_PUT,   CH_NEWLINE, 5'd1,  1'b1, 1'b0, CMD_LINE2}   // scroll of a blank store
  };

  logic clk = 1'b0;
  logic rst_n;

  lcdt_in_if  in_if ();
  lcdt_out_if out_if ();

  char_lcd_scrolling_terminal_unit #(
    .LINE_WIDTH(LINE_WIDTH)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // display model state
  bit          panel_ready;
  bit          cursor_line2;
  int unsigned cursor_col;
  logic [7:0]  line_text [LINE_WIDTH];

  lcd_xfer_t bus_xfers_due [$];

  int cycle_count;
  int mismatch_count;
  int items_sent;
  int sink_hold;
  bit calm;

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("ERROR cycle %0d: %s", cycle_count, what);
  endtask

  function automatic void post_xfer(input logic is_data, input logic [7:0] value,
                                    input logic nib);
    lcd_xfer_t x;
    x = '{is_data, value, nib, 1'b0};
    bus_xfers_due.push_back(x);
  endfunction

  // appends the transfers one item causes, returns how many
  function automatic int render_item(input logic op, input logic [7:0] ch);
    int start;
    lcd_xfer_t tail;
    start = bus_xfers_due.size();
    if (!panel_ready) begin
      repeat (3) post_xfer(1'b0, {4'h0, NIB_WAKE}, 1'b1);
      post_xfer(1'b0, {4'h0, NIB_4BIT}, 1'b1);
      post_xfer(1'b0, CMD_FUNCSET, 1'b0);
      post_xfer(1'b0, CMD_DISPOFF, 1'b0);
      post_xfer(1'b0, CMD_CLEAR, 1'b0);
      post_xfer(1'b0, CMD_ENTRY, 1'b0);
      post_xfer(1'b0, CMD_DISPON, 1'b0);
      panel_ready = 1'b1;
      cursor_col  = 0;
      for (int i = 0; i < LINE_WIDTH; i++) line_text[i] = BLANK;
    end
    if (op == OP_CLEAR) begin
      post_xfer(1'b0, CMD_CLEAR, 1'b0);
      cursor_line2 = 1'b0;
      cursor_col   = 0;
    end else if (ch == CH_NEWLINE) begin
      if (cursor_line2) begin
        post_xfer(1'b0, CMD_CLEAR, 1'b0);
        for (int i = 0; i < LINE_WIDTH; i++) begin
          post_xfer(1'b1, line_text[i], 1'b0);
          line_text[i] = BLANK;
        end
      end
      post_xfer(1'b0, CMD_LINE2, 1'b0);
      cursor_line2 = 1'b1;
      cursor_col   = 0;
    end else if (ch == CH_RETURN) begin
      post_xfer(1'b0, cursor_line2 ? CMD_LINE2 : CMD_HOME, 1'b0);
      cursor_col = 0;
    end else if (cursor_col < LINE_WIDTH) begin
      post_xfer(1'b1, ch, 1'b0);
      line_text[cursor_col] = ch;
      cursor_col++;
    end
    if (bus_xfers_due.size() > start) begin
      tail = bus_xfers_due.pop_back();
      tail.last = 1'b1;
      bus_xfers_due.push_back(tail);
    end
    return bus_xfers_due.size() - start;
  endfunction

  task automatic send_item(input logic op, input logic [7:0] ch, output int n);
    in_if.valid     <= 1'b1;
    in_if.op        <= op;
    in_if.char_code <= ch;
    do @(posedge clk); while (!in_if.ready);
    n = render_item(op, ch);
    items_sent++;
  endtask

  // sender gap before an item; drain waits until the display has caught up
  task automatic pace_sender(input bit drain);
    if (drain || (!calm && $urandom_range(0, 5) == 0)) begin
      in_if.valid <= 1'b0;
      if (drain) begin
        do @(posedge clk); while (bus_xfers_due.size() != 0);
      end
      if (!calm) repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // sink stalls in bursts
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold--;
      if (sink_hold == 0) out_if.ready <= 1'b1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_if.ready <= 1'b0;
      sink_hold = $urandom_range(1, 19);
    end
  end

  always @(posedge clk) begin
    lcd_xfer_t got;
    lcd_xfer_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{out_if.is_data, out_if.value, out_if.nibble_only, out_if.last};
      if (bus_xfers_due.size() == 0) begin
        flag_mismatch($sformatf("transfer %h with none pending", got));
      end else begin
        want = bus_xfers_due.pop_front();
        if (got.is_data !== want.is_data)
          flag_mismatch($sformatf("is_data %b, want %b", got.is_data, want.is_data));
        if (got.value !== want.value)
          flag_mismatch($sformatf("value %h, want %h", got.value, want.value));
        if (got.nibble_only !== want.nibble_only)
          flag_mismatch($sformatf("nibble_only %b, want %b", got.nibble_only,
                                  want.nibble_only));
        if (got.last !== want.last)
          flag_mismatch($sformatf("last %b, want %b", got.last, want.last));
      end
    end
  end

  initial begin
    int n;
    int len;
    int pick;
    logic op;
    logic [7:0] ch;
    lcd_xfer_t tail;

    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.op        = OP_PUT;
    in_if.char_code = 8'h00;
    out_if.ready    = 1'b1;
    panel_ready     = 1'b0;
    cursor_line2    = 1'b0;
    cursor_col      = 0;
    for (int i = 0; i < LINE_WIDTH; i++) line_text[i] = BLANK;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < $size(OPENING); r++) begin
      for (int k = 0; k < OPENING[r].reps; k++) begin
        pace_sender(1'b0);
        send_item(OPENING[r].op, OPENING[r].ch, n);
        if (OPENING[r].typed && n > 0) begin
          tail = bus_xfers_due.pop_back();
          tail.is_data = OPENING[r].t_is_data;
          tail.value   = OPENING[r].t_value;
          bus_xfers_due.push_back(tail);
        end
      end
    end

    // random text: runs of characters, most ended by a newline, return or clear, some noise mixed in
    while (items_sent < ITEM_TARGET) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 12);
      for (int k = 0; k <= len; k++) begin
        calm = (items_sent >= 120 && items_sent < 150) || (items_sent >= ITEM_TARGET - 40);
        pick = $urandom_range(0, 99);
        op   = OP_PUT;
        ch   = $urandom_range(0, 255);
        if (k < len) begin
          if (pick < 5) op = $urandom_range(0, 1);
          else if (ch == CH_NEWLINE || ch == CH_RETURN) ch = ch | 8'h20;
        end else if (pick < 60) begin
          ch = CH_NEWLINE;
        end else if (pick < 80) begin
          ch = CH_RETURN;
        end else if (pick < 92) begin
          op = OP_CLEAR;
        end
        pace_sender(items_sent == 170 || (!calm && $urandom_range(0, 49) == 0));
        send_item(op, ch, n);
      end
    end

    in_if.valid <= 1'b0;
    while (bus_xfers_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/lcdt_pkg.sv
hw/rtl/lcdt_if.sv
hw/rtl/lcdt_line_store.sv
hw/rtl/char_lcd_scrolling_terminal_unit.sv
test/char_lcd_scrolling_terminal_unit_tb.sv
